/* src/bls_pkg.sv */
// ----------------------------------------------------------------------------
// bls_pkg
// shared sizes, operation and status codes, and controller command type
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int DEPTH  = 16;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int ACT_W  = 2;
    localparam int POS_W  = 5;
    localparam int CAP_W  = 5;
    localparam int STAT_W = 2;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

    // operation codes
    localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS    = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
        logic load_out;
    } t_cmd;

endpackage

/* src/bls_in_if.sv */
// ----------------------------------------------------------------------------
// bls_in_if
// request channel: one operation word with valid/ready
// ----------------------------------------------------------------------------
interface bls_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [bls_pkg::ACT_W-1:0]             action;
    logic signed [bls_pkg::WORD_W-1:0]     push_value;
    logic [bls_pkg::POS_W-1:0]             position;

    modport source (output valid, output action, output push_value, output position,
                    input ready);
    modport sink   (input valid, input action, input push_value, input position,
                    output ready);
endinterface

/* src/bls_out_if.sv */
// ----------------------------------------------------------------------------
// bls_out_if
// result channel: one result word with valid/ready
// ----------------------------------------------------------------------------
interface bls_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bls_pkg::WORD_W-1:0]     data;
    logic [bls_pkg::STAT_W-1:0]            status;
    logic                                  is_empty;
    logic                                  is_full;
    logic [bls_pkg::CNT_W-1:0]             entry_count;
    logic signed [bls_pkg::WORD_W-1:0]     top_value;
    logic signed [bls_pkg::WORD_W-1:0]     bottom_value;

    modport source (output valid, output data, output status, output is_empty,
                    output is_full, output entry_count, output top_value,
                    output bottom_value, input ready);
    modport sink   (input valid, input data, input status, input is_empty,
                    input is_full, input entry_count, input top_value,
                    input bottom_value, output ready);
endinterface

/* src/bls_cfg_if.sv */
// ----------------------------------------------------------------------------
// bls_cfg_if
// configuration write channel for the capacity register
// ----------------------------------------------------------------------------
interface bls_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bls_pkg::CAP_W-1:0]     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/bls_ctrl.sv */
// ----------------------------------------------------------------------------
// bls_ctrl
// sequencer: capture, execute, then hand the result to the output register
// ----------------------------------------------------------------------------
module bls_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output bls_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   out_free;

    assign out_free       = !r_out_valid || i_out_ready;
    assign o_cmd.capture  = i_in_valid && r_in_ready;
    assign o_cmd.execute  = (r_state == S_EXEC);
    assign o_cmd.load_out = (r_state == S_FINISH) && out_free;
    assign o_in_ready     = r_in_ready;
    assign o_out_valid    = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.capture) begin
                        r_state    <= S_EXEC;
                        r_in_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    a_capture_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_EXEC) && !r_in_ready)
        else $error("captured word did not start execution");

    a_exec_to_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_FINISH))
        else $error("execute step did not move to finish");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid && r_in_ready && (r_state == S_IDLE))
        else $error("result load did not present a word and reopen input");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> (r_state == S_IDLE))
        else $error("input ready outside idle");

endmodule

/* src/bls_dp.sv */
// ----------------------------------------------------------------------------
// bls_dp
// stack datapath: entry memory, count, top/bottom cache and result register
// ----------------------------------------------------------------------------
module bls_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bls_pkg::t_cmd                         i_cmd,
    input  logic                                  i_cfg_we,
    input  logic [bls_pkg::CAP_W-1:0]             i_cfg_data,
    input  logic [bls_pkg::ACT_W-1:0]             i_action,
    input  logic signed [bls_pkg::WORD_W-1:0]     i_push_value,
    input  logic [bls_pkg::POS_W-1:0]             i_position,
    output logic signed [bls_pkg::WORD_W-1:0]     o_data,
    output logic [bls_pkg::STAT_W-1:0]            o_status,
    output logic                                  o_is_empty,
    output logic                                  o_is_full,
    output logic [bls_pkg::CNT_W-1:0]             o_entry_count,
    output logic signed [bls_pkg::WORD_W-1:0]     o_top_value,
    output logic signed [bls_pkg::WORD_W-1:0]     o_bottom_value
);

    logic [bls_pkg::WORD_W-1:0]         mem [bls_pkg::DEPTH];

    logic [bls_pkg::CAP_W-1:0]          r_capacity;
    logic [bls_pkg::CNT_W-1:0]          r_count;
    logic [bls_pkg::ACT_W-1:0]          r_action;
    logic signed [bls_pkg::WORD_W-1:0]  r_value;
    logic [bls_pkg::POS_W-1:0]          r_pos;
    logic signed [bls_pkg::WORD_W-1:0]  r_top;
    logic signed [bls_pkg::WORD_W-1:0]  r_bottom;
    logic signed [bls_pkg::WORD_W-1:0]  r_data;
    logic                               r_data_mem;
    logic                               r_top_reload;
    logic [bls_pkg::STAT_W-1:0]         r_status;
    logic signed [bls_pkg::WORD_W-1:0]  r_rdata;

    logic signed [bls_pkg::WORD_W-1:0]  r_o_data;
    logic [bls_pkg::STAT_W-1:0]         r_o_status;
    logic                               r_o_empty;
    logic                               r_o_full;
    logic [bls_pkg::CNT_W-1:0]          r_o_count;
    logic signed [bls_pkg::WORD_W-1:0]  r_o_top;
    logic signed [bls_pkg::WORD_W-1:0]  r_o_bottom;

    logic [bls_pkg::CMP_W-1:0]          cap_ext;
    logic [bls_pkg::CMP_W-1:0]          eff_cap;
    logic [bls_pkg::CMP_W-1:0]          cnt_ext;
    logic [bls_pkg::CMP_W-1:0]          pos_ext;
    logic [bls_pkg::CMP_W-1:0]          peek_diff;
    logic [bls_pkg::CNT_W-1:0]          pop_below;
    logic                               full;
    logic                               empty;
    logic                               push_ok;
    logic                               pop_ok;
    logic                               peek_ok;
    logic                               rd_en;
    logic [bls_pkg::AW-1:0]             rd_addr;
    logic [bls_pkg::STAT_W-1:0]         n_status;
    logic signed [bls_pkg::WORD_W-1:0]  cur_top;

    // effective capacity: zero acts as one, above the depth acts as the depth
    always_comb begin
        cap_ext = bls_pkg::CMP_W'(r_capacity);
        if (cap_ext == '0) begin
            eff_cap = bls_pkg::CMP_W'(1);
        end else if (cap_ext > bls_pkg::CMP_W'(bls_pkg::DEPTH)) begin
            eff_cap = bls_pkg::CMP_W'(bls_pkg::DEPTH);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign cnt_ext   = bls_pkg::CMP_W'(r_count);
    assign pos_ext   = bls_pkg::CMP_W'(r_pos);
    assign full      = (cnt_ext >= eff_cap);
    assign empty     = (r_count == '0);
    assign peek_diff = cnt_ext - pos_ext;
    assign pop_below = r_count - bls_pkg::CNT_W'(2);

    always_comb begin
        push_ok  = 1'b0;
        pop_ok   = 1'b0;
        peek_ok  = 1'b0;
        n_status = bls_pkg::ST_OK;
        case (r_action)
            bls_pkg::ACT_PUSH: begin
                push_ok  = !full;
                n_status = full ? bls_pkg::ST_OVERFLOW : bls_pkg::ST_OK;
            end
            bls_pkg::ACT_POP: begin
                pop_ok   = !empty;
                n_status = empty ? bls_pkg::ST_UNDERFLOW : bls_pkg::ST_OK;
            end
            bls_pkg::ACT_PEEK: begin
                peek_ok  = (r_pos != '0) && (pos_ext <= cnt_ext);
                n_status = peek_ok ? bls_pkg::ST_OK : bls_pkg::ST_BADPOS;
            end
            default: begin
                n_status = bls_pkg::ST_OK;
            end
        endcase
    end

    // one read per word: new top after a pop, or the peeked entry
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = peek_diff[bls_pkg::AW-1:0];
        if (i_cmd.execute && peek_ok) begin
            rd_en = 1'b1;
        end else if (i_cmd.execute && pop_ok && (r_count > bls_pkg::CNT_W'(1))) begin
            rd_en   = 1'b1;
            rd_addr = pop_below[bls_pkg::AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && push_ok) begin
            mem[r_count[bls_pkg::AW-1:0]] <= r_value;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= bls_pkg::CAP_RESET;
            r_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (i_cmd.execute && push_ok) begin
                r_count <= r_count + bls_pkg::CNT_W'(1);
            end else if (i_cmd.execute && pop_ok) begin
                r_count <= r_count - bls_pkg::CNT_W'(1);
            end
        end
    end

    assign cur_top = r_top_reload ? r_rdata : r_top;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_value  <= i_push_value;
            r_pos    <= i_position;
        end
        if (i_cmd.execute) begin
            r_status     <= n_status;
            r_data       <= pop_ok ? r_top : '0;
            r_data_mem   <= peek_ok;
            r_top_reload <= pop_ok && (r_count > bls_pkg::CNT_W'(1));
            if (push_ok) begin
                r_top <= r_value;
                if (empty) begin
                    r_bottom <= r_value;
                end
            end
        end
        if (i_cmd.load_out) begin
            r_top        <= cur_top;
            r_top_reload <= 1'b0;
            r_o_data     <= r_data_mem ? r_rdata : r_data;
            r_o_status   <= r_status;
            r_o_empty    <= empty;
            r_o_full     <= full;
            r_o_count    <= r_count;
            r_o_top      <= empty ? '0 : cur_top;
            r_o_bottom   <= empty ? '0 : r_bottom;
        end
    end

    assign o_data         = r_o_data;
    assign o_status       = r_o_status;
    assign o_is_empty     = r_o_empty;
    assign o_is_full      = r_o_full;
    assign o_entry_count  = r_o_count;
    assign o_top_value    = r_o_top;
    assign o_bottom_value = r_o_bottom;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bls_pkg::CMP_W'(r_count) <= bls_pkg::CMP_W'(bls_pkg::DEPTH))
        else $error("entry count beyond depth");

    a_count_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.execute |=> $stable(r_count))
        else $error("entry count moved outside execute");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.execute && push_ok) |=> (r_count == $past(r_count) + bls_pkg::CNT_W'(1)))
        else $error("accepted push did not grow the stack");

endmodule

/* src/bounded_lifo_stack_core.sv */
// ----------------------------------------------------------------------------
// bounded_lifo_stack_core
// bounded lifo stack of signed 32-bit words with programmable capacity
// ----------------------------------------------------------------------------
// Each request word is a push, a pop or a peek (position 1 is the top) and
// yields exactly one result word carrying the popped or peeked data, a status
// (ok, overflow, underflow, bad position) and the empty/full flags, count,
// top and bottom entries after the operation. Acceptance captures a request,
// the execute state then performs it (one memory write or one registered
// memory read) and the finish state loads the result register, which then
// presents the result. The input reopens with that load, so a request is
// taken only after the previous one has been executed and loaded. The load,
// and with it the reopening of the input, waits for as long as the output
// register still holds a word that has not been taken; a new request is taken
// while the previous result still waits in the output register. Capacity is
// written through the config channel, which is always ready; the user must
// write it only while no request is in flight, the block does not enforce
// this. A value of 0 acts as 1 and values above the depth act as the depth.
// Entries live in a 16-word memory with one read and one write port and are
// only read at positions that a push has written, so no clearing pass
// follows reset.
// ----------------------------------------------------------------------------
module bounded_lifo_stack_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bls_in_if.sink     i_req,
    bls_out_if.source  o_rsp,
    bls_cfg_if.sink    i_cfg
);

    bls_pkg::t_cmd cmd;
    logic          in_ready;
    logic          out_valid;

    // config register write is always accepted
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

    // sequencer: owns both handshakes
    bls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    // datapath: entry memory, count, top/bottom cache, result register
    bls_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_data     (i_cfg.data),
        .i_action       (i_req.action),
        .i_push_value   (i_req.push_value),
        .i_position     (i_req.position),
        .o_data         (o_rsp.data),
        .o_status       (o_rsp.status),
        .o_is_empty     (o_rsp.is_empty),
        .o_is_full      (o_rsp.is_full),
        .o_entry_count  (o_rsp.entry_count),
        .o_top_value    (o_rsp.top_value),
        .o_bottom_value (o_rsp.bottom_value)
    );

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bounded lifo stack core
// ----------------------------------------------------------------------------
// A short table of directed operations runs first at the reset capacity. It
// covers an empty stack, the word extremes, peeks at bad positions, a full
// stack and the unused action code. Random phases follow. Each phase first
// programs a new capacity while the core is idle: zero, above the depth, the
// extremes, and values below the current fill. Then it sends a stream whose
// mix drifts between filling, draining and browsing. A local stack model
// predicts every result word that no table row writes out; the checker
// compares each received word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bls_pkg::*;

    // unused action code, the core treats it as a no-op
    localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

    localparam int N_PHASES    = 9;
    localparam int PHASE_ITEMS = 190;
    localparam int TAIL_ITEMS  = 20;
    // limit for about 1750 words in the worst idling mix
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic [STAT_W-1:0]        status;
        logic                     is_empty;
        logic                     is_full;
        logic [CNT_W-1:0]         entry_count;
        logic signed [WORD_W-1:0] top_value;
        logic signed [WORD_W-1:0] bottom_value;
    } stack_result_t;

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [WORD_W-1:0] value;
        logic [POS_W-1:0]  pos;
        bit                typed;
        stack_result_t     want;
    } op_row_t;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BROWSE} op_mix_t;

    logic clk = 1'b0;
    logic rst_n;

    bls_in_if  req_if();
    bls_out_if rsp_if();
    bls_cfg_if cfg_if();

    bounded_lifo_stack_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // local copy of the stack and the capacity register
    logic [WORD_W-1:0] stack_words [DEPTH];
    int unsigned       stack_fill;
    logic [CAP_W-1:0]  capacity_reg;

    stack_result_t outstanding_results[$];
    op_row_t       directed_ops[$];
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;
    int unsigned   snd_idle_pct = 25;
    int unsigned   rsp_idle_pct = 46;

    // apply one operation to the local stack, return the word the core owes
    function automatic stack_result_t apply_stack_op(input logic [ACT_W-1:0] act,
                                                     input logic [WORD_W-1:0] value,
                                                     input logic [POS_W-1:0] pos);
        stack_result_t r;
        int unsigned   eff_cap;
        eff_cap = (capacity_reg == 0) ? 1 :
                  (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_PUSH: begin
                // full also covers a fill left above a lowered capacity
                if (stack_fill >= eff_cap || stack_fill >= DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    stack_words[stack_fill] = value;
                    stack_fill++;
                end
            end
            ACT_POP: begin
                if (stack_fill == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    stack_fill--;
                    r.data = stack_words[stack_fill];
                end
            end
            ACT_PEEK: begin
                if (pos == 0 || pos > stack_fill) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.data = stack_words[stack_fill - pos];
                end
            end
            default: begin
                // no-op, flags only
            end
        endcase
        r.is_empty    = (stack_fill == 0);
        r.is_full     = (stack_fill >= eff_cap);
        r.entry_count = CNT_W'(stack_fill);
        r.top_value    = (stack_fill == 0) ? '0 : stack_words[stack_fill - 1];
        r.bottom_value = (stack_fill == 0) ? '0 : stack_words[0];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("[%0t] %s: got %h, want %h", $time, field, got, want);
        mismatch_count++;
    endtask

    // directed row whose result comes from the model
    task automatic add_op(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] value,
                          input logic [POS_W-1:0] pos);
        op_row_t row;
        row.act   = act;
        row.value = value;
        row.pos   = pos;
        row.typed = 1'b0;
        row.want  = '0;
        directed_ops.push_back(row);
    endtask

    // directed row with its result written out
    task automatic add_checked(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] value,
                               input logic [POS_W-1:0] pos, input logic [WORD_W-1:0] data,
                               input logic [STAT_W-1:0] status, input logic full,
                               input int unsigned cnt, input logic [WORD_W-1:0] top,
                               input logic [WORD_W-1:0] bottom);
        op_row_t row;
        row.act   = act;
        row.value = value;
        row.pos   = pos;
        row.typed = 1'b1;
        row.want.data         = data;
        row.want.status       = status;
        row.want.is_empty     = (cnt == 0);
        row.want.is_full      = full;
        row.want.entry_count  = CNT_W'(cnt);
        row.want.top_value    = top;
        row.want.bottom_value = bottom;
        directed_ops.push_back(row);
    endtask

    // sender idles at random per cycle before the next word
    task automatic idle_gap();
        while ($urandom_range(99) < snd_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // hold off the sender until every outstanding result word has come back
    task automatic drain_results();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (outstanding_results.size() != 0);
    endtask

    // present one word, wait for the handshake, then record the prediction
    task automatic issue_op(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] value,
                            input logic [POS_W-1:0] pos, input bit typed,
                            input stack_result_t want);
        stack_result_t pred;
        req_if.valid      <= 1'b1;
        req_if.action     <= act;
        req_if.push_value <= value;
        req_if.position   <= pos;
        do @(posedge clk); while (!req_if.ready);
        pred = apply_stack_op(act, value, pos);
        outstanding_results.push_back(typed ? want : pred);
    endtask

    // capacity is only written with nothing in flight
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= cap;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        capacity_reg = cap;
    endtask

    // result side: check accepted words and stall at random
    initial begin
        stack_result_t want;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready) begin
                if (outstanding_results.size() == 0) begin
                    report_mismatch("result word with nothing outstanding", rsp_if.data, '0);
                end else begin
                    want = outstanding_results.pop_front();
                    if (rsp_if.data !== want.data)
                        report_mismatch("data", rsp_if.data, want.data);
                    if (rsp_if.status !== want.status)
                        report_mismatch("status", WORD_W'(rsp_if.status), WORD_W'(want.status));
                    if (rsp_if.is_empty !== want.is_empty)
                        report_mismatch("is_empty", WORD_W'(rsp_if.is_empty),
                                        WORD_W'(want.is_empty));
                    if (rsp_if.is_full !== want.is_full)
                        report_mismatch("is_full", WORD_W'(rsp_if.is_full),
                                        WORD_W'(want.is_full));
                    if (rsp_if.entry_count !== want.entry_count)
                        report_mismatch("entry_count", WORD_W'(rsp_if.entry_count),
                                        WORD_W'(want.entry_count));
                    if (rsp_if.top_value !== want.top_value)
                        report_mismatch("top_value", rsp_if.top_value, want.top_value);
                    if (rsp_if.bottom_value !== want.bottom_value)
                        report_mismatch("bottom_value", rsp_if.bottom_value, want.bottom_value);
                end
            end
            rsp_if.ready <= (rsp_idle_pct == 0) || ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        op_row_t          row;
        op_mix_t          mix;
        logic [CAP_W-1:0] phase_caps [N_PHASES];
        logic [ACT_W-1:0] act;
        logic [WORD_W-1:0] value;
        logic [POS_W-1:0] pos;
        int unsigned      roll;
        int unsigned      push_pct;
        int unsigned      pop_pct;
        int unsigned      mix_left;

        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.action     = ACT_PUSH;
        req_if.push_value = '0;
        req_if.position   = '0;
        rsp_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.data       = '0;

        stack_fill   = 0;
        capacity_reg = CAP_RESET;
        foreach (stack_words[i]) stack_words[i] = '0;

        // directed table, capacity at its reset value of 10
        // empty stack: underflow, bad position, no-op
        add_checked(ACT_POP,  32'hA5A5_5A5A, 5'd1,  '0, ST_UNDERFLOW, 1'b0, 0, '0, '0);
        add_checked(ACT_PEEK, 32'h5A5A_A5A5, 5'd1,  '0, ST_BADPOS,    1'b0, 0, '0, '0);
        add_checked(ACT_NOP,  32'hFFFF_FFFF, 5'd31, '0, ST_OK,        1'b0, 0, '0, '0);
        // word extremes
        add_checked(ACT_PUSH, 32'h7FFF_FFFF, 5'd0, '0, ST_OK, 1'b0, 1,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_checked(ACT_PUSH, 32'h8000_0000, 5'd0, '0, ST_OK, 1'b0, 2,
                    32'h8000_0000, 32'h7FFF_FFFF);
        // peek at position zero, just past the fill, at the field maximum and at both entries
        add_checked(ACT_PEEK, 32'h0000_0000, 5'd0,  '0, ST_BADPOS, 1'b0, 2,
                    32'h8000_0000, 32'h7FFF_FFFF);
        add_checked(ACT_PEEK, 32'hFFFF_FFFF, 5'd3,  '0, ST_BADPOS, 1'b0, 2,
                    32'h8000_0000, 32'h7FFF_FFFF);
        add_checked(ACT_PEEK, 32'h1234_5678, 5'd31, '0, ST_BADPOS, 1'b0, 2,
                    32'h8000_0000, 32'h7FFF_FFFF);
        add_checked(ACT_PEEK, 32'h0000_0000, 5'd2, 32'h7FFF_FFFF, ST_OK, 1'b0, 2,
                    32'h8000_0000, 32'h7FFF_FFFF);
        add_checked(ACT_PEEK, 32'h0000_0000, 5'd1, 32'h8000_0000, ST_OK, 1'b0, 2,
                    32'h8000_0000, 32'h7FFF_FFFF);
        // fill up to the capacity
        add_op(ACT_PUSH, 32'hFFFF_FFFF, 5'd31);
        add_op(ACT_PUSH, 32'h0000_0000, 5'd16);
        add_op(ACT_PUSH, 32'h5555_5555, 5'd0);
        add_op(ACT_PUSH, 32'hAAAA_AAAA, 5'd7);
        add_op(ACT_PUSH, 32'h0000_0001, 5'd0);
        add_op(ACT_PUSH, 32'h1234_5678, 5'd0);
        add_op(ACT_PUSH, 32'h8765_4321, 5'd0);
        add_op(ACT_PUSH, 32'h0F0F_0F0F, 5'd0);
        // push onto a full stack
        add_checked(ACT_PUSH, 32'hDEAD_BEEF, 5'd0, '0, ST_OVERFLOW, 1'b1, 10,
                    32'h0F0F_0F0F, 32'h7FFF_FFFF);
        add_op(ACT_PEEK, 32'hC3C3_3C3C, 5'd10);
        add_op(ACT_PEEK, 32'h3C3C_C3C3, 5'd11);
        add_op(ACT_PEEK, 32'h0000_0000, 5'd16);
        add_op(ACT_POP,  32'hFFFF_FFFF, 5'd31);
        add_op(ACT_NOP,  32'h0000_0000, 5'd0);
        add_op(ACT_POP,  32'h0000_0000, 5'd5);

        // capacities per phase; every phase ends push-heavy so a lower value
        // lands below the fill
        phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd2, 5'd12, 5'd3};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_ops[i]) begin
            row = directed_ops[i];
            idle_gap();
            issue_op(row.act, row.value, row.pos, row.typed, row.want);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // idling: sender light / receiver heavy, then swapped, then none
            if (ph < 3) begin
                snd_idle_pct = 25;
                rsp_idle_pct = 46;
            end else if (ph < 6) begin
                snd_idle_pct = 46;
                rsp_idle_pct = 25;
            end else begin
                snd_idle_pct = 0;
                rsp_idle_pct = 0;
            end
            write_capacity(phase_caps[ph]);
            mix_left = 0;
            mix = MIX_FILL;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (mix_left == 0) begin
                    mix = op_mix_t'($urandom_range(2));
                    mix_left = $urandom_range(16, 32);
                end
                mix_left--;
                case (mix)
                    MIX_FILL:  begin push_pct = 65; pop_pct = 20; end
                    MIX_DRAIN: begin push_pct = 20; pop_pct = 65; end
                    default:   begin push_pct = 30; pop_pct = 25; end
                endcase
                if (n >= PHASE_ITEMS - TAIL_ITEMS) begin
                    push_pct = 90;
                    pop_pct  = 4;
                end
                roll = $urandom_range(99);
                if (roll < push_pct)                 act = ACT_PUSH;
                else if (roll < push_pct + pop_pct)  act = ACT_POP;
                else if (roll < 97)                  act = ACT_PEEK;
                else                                 act = ACT_NOP;

                case ($urandom_range(7))
                    0:       value = 32'h7FFF_FFFF;
                    1:       value = 32'h8000_0000;
                    2:       value = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
                    default: value = $urandom;
                endcase

                // peeks mostly inside the fill, some at the edges, some anywhere
                roll = $urandom_range(99);
                if (roll < 70)
                    pos = POS_W'($urandom_range(1, (stack_fill == 0) ? 1 : stack_fill));
                else if (roll < 85)
                    pos = ($urandom_range(1) != 0) ? '0 : POS_W'(stack_fill + 1);
                else
                    pos = POS_W'($urandom_range(31));

                // hold off until the core has gone quiet, at least once per run
                if ((ph == 0 && n == 50) || $urandom_range(59) == 0)
                    drain_results();
                else
                    idle_gap();
                issue_op(act, value, pos, 1'b0, '0);
            end
        end

        req_if.valid <= 1'b0;
        do @(posedge clk); while (outstanding_results.size() != 0);
        // wait past the final result to catch stray words
        repeat (12) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
